@@ hw/rtl/rilin_pkg.sv @@
package rilin_pkg;

  // Fixed field widths of the block.
  localparam int NDIM      = 4;
  localparam int CRD_W     = 12;
  localparam int EXT_W     = 13;
  localparam int FLAT_W    = 48;
  localparam int ACC_W     = NDIM * EXT_W;
  localparam int DIV_STEPS = 4;
  localparam int CFG_AW    = 3;

  // Stream word layouts.
  localparam int IN_DW        = NDIM * CRD_W + FLAT_W;
  localparam int OUT_POS_LSB  = FLAT_W;
  localparam int OUT_STAT_LSB = FLAT_W + NDIM * CRD_W;
  localparam int OUT_RAW_W    = OUT_STAT_LSB + 2;
  localparam int OUT_DW       = ((OUT_RAW_W + 7) / 8) * 8;

  typedef enum logic [CFG_AW-1:0] {
    REG_LOWER_0 = 3'd0,
    REG_LOWER_1 = 3'd1,
    REG_LOWER_2 = 3'd2,
    REG_LOWER_3 = 3'd3,
    REG_UPPER_0 = 3'd4,
    REG_UPPER_1 = 3'd5,
    REG_UPPER_2 = 3'd6,
    REG_UPPER_3 = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_OUTSIDE = 2'd1,
    STAT_BAD_BOX = 2'd2
  } status_e;

  localparam logic CMD_FLATTEN = 1'b0;

  typedef logic [NDIM-1:0][EXT_W-1:0] ext_vec_t;
  typedef logic [NDIM-1:0][CRD_W-1:0] crd_vec_t;

  // Payload that travels down the pipeline with each word.
  typedef struct packed {
    logic                    cmd;
    logic                    box_ok;
    logic                    in_box;
    logic                    too_big;
    logic [ACC_W-1:0]        acc;
    logic [ACC_W-1:0]        total;
    logic [EXT_W+FLAT_W-1:0] dw;
    crd_vec_t                off;
    crd_vec_t                pos;
  } pipe_t;

endpackage

@@ hw/rtl/rilin_mac.sv @@
module rilin_mac #(
  parameter int DIM = 0
) (
  input  logic              clk,
  input  logic              en,
  input  rilin_pkg::ext_vec_t ext,
  input  rilin_pkg::pipe_t  p_i,
  output rilin_pkg::pipe_t  p_o
);
  import rilin_pkg::*;

  logic [ACC_W+EXT_W-1:0] acc_prod;
  logic [ACC_W+EXT_W-1:0] tot_prod;
  pipe_t                  p_nxt;
  pipe_t                  p_r;

  // One row-major step: the offset so far is scaled by this extent.
  always_comb begin
    p_nxt    = p_i;
    acc_prod = p_i.acc * ext[DIM];
    tot_prod = p_i.total * ext[DIM];
    p_nxt.acc   = acc_prod[ACC_W-1:0] + ACC_W'(p_i.off[DIM]);
    p_nxt.total = tot_prod[ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign p_o = p_r;

endmodule

@@ hw/rtl/rilin_div.sv @@
module rilin_div #(
  parameter int DIM  = 0,
  parameter bit LAST = 1'b0
) (
  input  logic                clk,
  input  logic                en,
  input  rilin_pkg::ext_vec_t ext,
  input  rilin_pkg::crd_vec_t lower,
  input  rilin_pkg::pipe_t    p_i,
  output rilin_pkg::pipe_t    p_o
);
  import rilin_pkg::*;

  logic [EXT_W-1:0]  rem;
  logic [FLAT_W-1:0] dq;
  logic [EXT_W:0]    trial;
  logic              qbit;
  logic [EXT_W-1:0]  pos_sum;
  pipe_t             p_nxt;
  pipe_t             p_r;

  // Restoring division, DIV_STEPS (four) quotient bits per stage. The dividend shifts
  // out of the top of dq while the quotient bits fill it from the bottom.
  always_comb begin
    p_nxt = p_i;
    rem   = p_i.dw[FLAT_W +: EXT_W];
    dq    = p_i.dw[FLAT_W-1:0];
    trial = '0;
    qbit  = 1'b0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {rem, dq[FLAT_W-1]};
      if (trial >= {1'b0, ext[DIM]}) begin
        trial = trial - {1'b0, ext[DIM]};
        qbit  = 1'b1;
      end else begin
        qbit  = 1'b0;
      end
      rem = trial[EXT_W-1:0];
      dq  = {dq[FLAT_W-2:0], qbit};
    end
    pos_sum = rem + {1'b0, lower[DIM]};
    if (LAST) begin
      p_nxt.pos[DIM] = pos_sum[CRD_W-1:0];
      p_nxt.dw       = {{EXT_W{1'b0}}, dq};
    end else begin
      p_nxt.dw       = {rem, dq};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign p_o = p_r;

endmodule

@@ hw/rtl/region_index_linearizer_unit.sv @@
// Channel | Direction | Carries
// in_     | slave     | tdata: coord_0..coord_3, flat_in; tuser: command
// out_    | master    | tdata: flat_out, pos_0..pos_3, status
// cfg_    | write     | lower_0..lower_3, upper_0..upper_3 by index
//
// One word enters per cycle unless the output is held; each word passes the
// front stage, the multiply stages, the check stage, twelve radix-2 division
// stages per dimension of four quotient bits each, and the output register.
// Reset is synchronous and active low; it clears the valid bits and restores
// the box to lower 0, upper 1 in every dimension.
// The whole pipeline advances together; when the output word is held the
// pipeline holds too, so nothing is dropped or repeated.
module region_index_linearizer_unit #(
  parameter int RANK       = 4,
  parameter int COORD_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [rilin_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [rilin_pkg::EXT_W-1:0]    cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // coord_0 [11:0], coord_1 [23:12], coord_2 [35:24], coord_3 [47:36],
  // flat_in [95:48]
  input  logic [rilin_pkg::IN_DW-1:0]    in_tdata,
  // command [0]
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // flat_out [47:0], pos_0 [59:48], pos_1 [71:60], pos_2 [83:72],
  // pos_3 [95:84], status [97:96], zero [103:98]
  output logic [rilin_pkg::OUT_DW-1:0]   out_tdata
);
  import rilin_pkg::*;

  // Only the leading dimensions up to the rank take part.
  localparam int ACT  = (RANK < NDIM) ? RANK : NDIM;
  localparam int DSTG = FLAT_W / DIV_STEPS;
  localparam int NST  = 2 + ACT + ACT * DSTG;
  localparam int PB   = (COORD_BITS < CRD_W) ? COORD_BITS : CRD_W;
  localparam logic [CRD_W-1:0] POS_MASK = {CRD_W{1'b1}} >> (CRD_W - PB);

  crd_vec_t              lower_r;
  ext_vec_t              upper_r;
  ext_vec_t              ext;
  logic                  box_ok;
  logic                  en;
  logic [NST-1:0]        vld_r;
  logic                  out_valid_r;
  logic [OUT_DW-1:0]     out_data_r;
  logic [OUT_DW-1:0]     out_data_nxt;
  pipe_t                 front_nxt;
  pipe_t                 front_r;
  pipe_t                 chk_nxt;
  pipe_t                 chk_r;
  pipe_t                 stage_q [NST];

  // Configuration registers. The user changes the box only while the block is
  // idle; the block does not enforce this, and every stage reads the live values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < NDIM; d++) begin
        lower_r[d] <= '0;
        upper_r[d] <= EXT_W'(1);
      end
    end else if (cfg_wr_en) begin
      case (cfg_reg_e'(cfg_addr))
        REG_LOWER_0: lower_r[0] <= cfg_wdata[CRD_W-1:0];
        REG_LOWER_1: lower_r[1] <= cfg_wdata[CRD_W-1:0];
        REG_LOWER_2: lower_r[2] <= cfg_wdata[CRD_W-1:0];
        REG_LOWER_3: lower_r[3] <= cfg_wdata[CRD_W-1:0];
        REG_UPPER_0: upper_r[0] <= cfg_wdata;
        REG_UPPER_1: upper_r[1] <= cfg_wdata;
        REG_UPPER_2: upper_r[2] <= cfg_wdata;
        REG_UPPER_3: upper_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Extents, and the box check over the active dimensions. An empty or
  // inverted box leaves a meaningless extent, but its results are masked.
  always_comb begin
    box_ok = 1'b1;
    for (int d = 0; d < NDIM; d++) begin
      ext[d] = upper_r[d] - {1'b0, lower_r[d]};
      if (d < ACT && {1'b0, lower_r[d]} >= upper_r[d]) begin
        box_ok = 1'b0;
      end
    end
  end

  // The pipeline moves as one; the output register is its last stage.
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // Front stage: unpack, range check and offsets from the lower bounds.
  always_comb begin
    front_nxt         = '0;
    front_nxt.cmd     = in_tuser;
    front_nxt.box_ok  = box_ok;
    front_nxt.in_box  = 1'b1;
    front_nxt.total   = ACC_W'(1);
    front_nxt.dw      = {{EXT_W{1'b0}}, in_tdata[NDIM*CRD_W +: FLAT_W]};
    for (int d = 0; d < NDIM; d++) begin
      if (d < ACT) begin
        if (in_tdata[d*CRD_W +: CRD_W] < lower_r[d] ||
            {1'b0, in_tdata[d*CRD_W +: CRD_W]} >= upper_r[d]) begin
          front_nxt.in_box = 1'b0;
        end
        front_nxt.off[d] = in_tdata[d*CRD_W +: CRD_W] - lower_r[d];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front_r <= front_nxt;
    end
  end

  assign stage_q[0] = front_r;

  // Horner accumulation of the flat offset and of the element count.
  for (genvar s = 0; s < ACT; s++) begin : g_mac
    rilin_mac #(.DIM(s)) u_mac (
      .clk (clk),
      .en  (en),
      .ext (ext),
      .p_i (stage_q[s]),
      .p_o (stage_q[s+1])
    );
  end

  // The element count is now known; flag an offset at or past it.
  always_comb begin
    chk_nxt         = stage_q[ACT];
    chk_nxt.too_big = {{(ACC_W-FLAT_W){1'b0}}, stage_q[ACT].dw[FLAT_W-1:0]}
                      >= stage_q[ACT].total;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chk_r <= chk_nxt;
    end
  end

  assign stage_q[ACT+1] = chk_r;

  // Peel the offset by each extent from the innermost dimension outward.
  for (genvar k = 0; k < ACT * DSTG; k++) begin : g_div
    rilin_div #(
      .DIM  (ACT - 1 - k / DSTG),
      .LAST ((k % DSTG) == DSTG - 1)
    ) u_div (
      .clk   (clk),
      .en    (en),
      .ext   (ext),
      .lower (lower_r),
      .p_i   (stage_q[ACT+1+k]),
      .p_o   (stage_q[ACT+2+k])
    );
  end

  // Result selection: the box check wins over the range checks.
  always_comb begin
    out_data_nxt = '0;
    if (!stage_q[NST-1].box_ok) begin
      out_data_nxt[OUT_STAT_LSB +: 2] = STAT_BAD_BOX;
    end else if (stage_q[NST-1].cmd == CMD_FLATTEN) begin
      if (stage_q[NST-1].in_box) begin
        out_data_nxt[FLAT_W-1:0] = stage_q[NST-1].acc[FLAT_W-1:0];
      end else begin
        out_data_nxt[OUT_STAT_LSB +: 2] = STAT_OUTSIDE;
      end
    end else begin
      for (int d = 0; d < NDIM; d++) begin
        if (d < ACT) begin
          out_data_nxt[OUT_POS_LSB + d*CRD_W +: CRD_W] =
            stage_q[NST-1].pos[d] & POS_MASK;
        end
      end
      if (stage_q[NST-1].too_big) begin
        out_data_nxt[OUT_STAT_LSB +: 2] = STAT_OUTSIDE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NST-2:0], in_tvalid};
      out_valid_r <= vld_r[NST-1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_STAT_LSB +: 2] != 2'd3)
    else $error("status code out of range");

  a_bad_box_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_STAT_LSB +: 2] == STAT_BAD_BOX
      |-> out_tdata[OUT_STAT_LSB-1:0] == '0)
    else $error("invalid box word carries data");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted word not in first stage");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("pipeline stalled without output back-pressure");

endmodule
